// ===== hdl/geffe_lfsr_stream_cipher_assert.svh =====
// Assertion macros for the Geffe stream cipher block.
`ifndef GEFFE_LFSR_STREAM_CIPHER_ASSERT_SVH
`define GEFFE_LFSR_STREAM_CIPHER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define GEFFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define GEFFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GEFFE_ASSERT(lbl, prop, msg)
`define GEFFE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/geffe_pkg.sv =====
// Types and constants shared by the Geffe stream cipher modules.
package geffe_pkg;

  localparam int NUM_LFSR = 11;
  localparam int LFSR_W   = 32;
  localparam int ROUNDS   = 8;

  localparam logic [LFSR_W-1:0] HASH_SALT = 32'h5A5A_5A5A;

  typedef enum logic [1:0] {
    REQ_KEY  = 2'd0,
    REQ_SEED = 2'd1,
    REQ_DATA = 2'd2
  } req_kind_t;

  localparam logic [LFSR_W-1:0] TAP_MASK [NUM_LFSR] = '{
    32'h0000_B400, 32'h0000_E000, 32'h8020_0003, 32'h8000_0057,
    32'h8000_0062, 32'h4000_0018, 32'h1000_0002, 32'h2000_0029,
    32'h0080_000D, 32'h0020_0001, 32'h0008_0005
  };

  // Register index times 0x12345678, modulo 2^32.
  localparam logic [LFSR_W-1:0] SEED_OFS [NUM_LFSR] = '{
    32'h0000_0000, 32'h1234_5678, 32'h2468_ACF0, 32'h369D_0368,
    32'h48D1_59E0, 32'h5B05_B058, 32'h6D3A_06D0, 32'h7F6E_5D48,
    32'h91A2_B3C0, 32'hA3D7_0A38, 32'hB60B_60B0
  };

  typedef struct packed {
    logic key_load;
    logic seed_load;
    logic data_step;
  } ctrl_t;

endpackage

// ===== hdl/geffe_key_hash.sv =====
// Key hash register: folds key bytes, returns to the salt on seeding.
module geffe_key_hash import geffe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_t             ctrl,
  input  logic [7:0]        key_byte,
  output logic [LFSR_W-1:0] hash
);

  logic [LFSR_W-1:0] hash_r;
  logic [LFSR_W-1:0] hash_nxt;

  always_comb begin
    hash_nxt = hash_r;
    if (ctrl.seed_load) begin
      hash_nxt = HASH_SALT;
    end else if (ctrl.key_load) begin
      // signed-char byte, sign extended
      hash_nxt = (hash_r << 5) ^ hash_r ^ {{(LFSR_W-8){key_byte[7]}}, key_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= HASH_SALT;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

// ===== hdl/geffe_lfsr_bank.sv =====
// Eleven Galois LFSRs with seeding and an eight-round Geffe keystream byte.
module geffe_lfsr_bank import geffe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_t             ctrl,
  input  logic [LFSR_W-1:0] hash,
  output logic [7:0]        ks_byte
);

  logic [LFSR_W-1:0] lfsr_r   [NUM_LFSR];
  logic [LFSR_W-1:0] lfsr_nxt [NUM_LFSR];
  logic [LFSR_W-1:0] stepped  [NUM_LFSR];
  logic [LFSR_W-1:0] seed     [NUM_LFSR];

  // Eight unrolled rounds; each round steps all registers once.
  always_comb begin
    logic [NUM_LFSR-1:0] b;
    logic [LFSR_W-1:0]   st [NUM_LFSR];
    logic [7:0]          ks;
    st = lfsr_r;
    ks = '0;
    b  = '0;
    for (int rd = 0; rd < ROUNDS; rd++) begin
      for (int r = 0; r < NUM_LFSR; r++) begin
        b[r]  = st[r][0];
        st[r] = {1'b0, st[r][LFSR_W-1:1]} ^ (b[r] ? TAP_MASK[r] : '0);
      end
      ks[ROUNDS-1-rd] = (b[0] ? b[1] : b[2]) ^ (b[3] ? b[4] : b[5])
                      ^ (b[6] ? b[7] : b[8]) ^ b[9] ^ b[10];
    end
    stepped = st;
    ks_byte = ks;
  end

  always_comb begin
    for (int r = 0; r < NUM_LFSR; r++) begin
      seed[r] = hash ^ SEED_OFS[r];
      if (seed[r] == '0) begin
        seed[r] = {{(LFSR_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (ctrl.seed_load) begin
      lfsr_nxt = seed;
    end else if (ctrl.data_step) begin
      lfsr_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_LFSR; r++) begin
        lfsr_r[r] <= '0;
      end
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule

// ===== hdl/geffe_lfsr_stream_cipher.sv =====
// Top level of the Geffe-combined LFSR stream cipher.
// One request beat per cycle: key beats fold a byte into the 32-bit key
// hash, seed beats load all eleven LFSRs from the hash (and reset the hash
// to its salt), data beats XOR the byte with the next keystream byte and
// emit one result beat. Key and seed beats give no result. Each beat is
// captured in an input register and finished by the eight-round keystream
// logic, which also updates the LFSR state; a data result is registered in
// the output register as its beat finishes, and sustained rate is one beat
// per clock while results are drained. The input side
// stalls only when a data beat waits on a full output register that is not
// being drained. Request type 3 is accepted and dropped. Before the first
// seed the LFSRs are zero and data passes through unchanged.
`include "geffe_lfsr_stream_cipher_assert.svh"

module geffe_lfsr_stream_cipher import geffe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);

  // input register
  logic       in_vld_r;
  logic       in_vld_nxt;
  logic [1:0] in_req_r;
  logic [7:0] in_val_r;

  // result register
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic [7:0] out_byte_r;

  logic              is_data;
  logic              fire;
  ctrl_t             ctrl;
  logic [LFSR_W-1:0] hash;
  logic [7:0]        ks_byte;

  assign is_data = (in_req_r == REQ_DATA);
  // Beat in the input register completes unless its result has nowhere to go.
  assign fire    = in_vld_r && (!is_data || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  always_comb begin
    ctrl = '0;
    if (fire) begin
      unique case (in_req_r)
        REQ_KEY:  ctrl.key_load  = 1'b1;
        REQ_SEED: ctrl.seed_load = 1'b1;
        REQ_DATA: ctrl.data_step = 1'b1;
        default:  ctrl = '0;
      endcase
    end
  end

  geffe_key_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .key_byte (in_val_r),
    .hash     (hash)
  );

  geffe_lfsr_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .hash    (hash),
    .ks_byte (ks_byte)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (ctrl.data_step) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r <= in_req_type;
      in_val_r <= in_value;
    end
    if (ctrl.data_step) begin
      out_byte_r <= in_val_r ^ ks_byte;
    end
  end

  assign out_valid = out_vld_r;
  assign out_byte  = out_byte_r;

  `GEFFE_ASSERT(a_data_gives_result, fire && is_data |=> out_vld_r, "data beat lost its result")
  `GEFFE_ASSERT(a_no_overwrite, in_vld_r && is_data && out_vld_r && !out_ready |-> !fire, "result overwritten")
  `GEFFE_ASSERT(a_seed_salts_hash, ctrl.seed_load |=> hash == HASH_SALT, "hash not salted after seed")
  `GEFFE_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_vld_r && !in_vld_r, "reset left a beat pending")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Geffe LFSR stream cipher top level.
`timescale 1ns / 100ps

module tb_top;
  import geffe_pkg::*;

  localparam int          N_LFSR      = 11;
  localparam logic [31:0] SALT        = 32'h5A5A_5A5A;
  localparam logic [31:0] STRIDE      = 32'h1234_5678;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;   // accepted and dropped
  localparam int          HOLD_CYCLES = 300;    // long sink back-pressure
  localparam int          TAIL_CYCLES = 8;      // short tail after the last result

  localparam logic [31:0] LFSR_TAPS [N_LFSR] = '{
    32'h0000_B400, 32'h0000_E000, 32'h8020_0003, 32'h8000_0057,
    32'h8000_0062, 32'h4000_0018, 32'h1000_0002, 32'h2000_0029,
    32'h0080_000D, 32'h0020_0001, 32'h0008_0005
  };

  typedef struct {
    logic [1:0] req;
    logic [7:0] value;
    bit         has_fixed;  // expected byte written out by hand
    logic [7:0] fixed_out;
  } stim_row_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = REQ_KEY;
  logic [7:0] in_value    = 8'h00;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_byte;

  // Shadow copy of the cipher state, advanced once per accepted input beat.
  logic [31:0] ks_lfsr [N_LFSR];
  logic [31:0] ks_hash;
  logic [7:0]  expected_bytes [$];

  int mismatch_cnt = 0;
  bit steady       = 1'b0;  // no idling on either side while set
  bit hold_sink    = 1'b0;  // request a long out_ready hold-off

  stim_row_t directed_rows [$];

  always #4 clk = ~clk;

  geffe_lfsr_stream_cipher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte)
  );

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(25, 70);
  endfunction

  // Cipher predictor: applies one request to the shadow state and returns
  // the output byte for data requests.
  task automatic cipher_apply(input logic [1:0] kind, input logic [7:0] val,
                              output bit has_out, output logic [7:0] ks_out);
    logic [31:0] ofs, seed;
    logic [N_LFSR-1:0] b;
    logic [7:0] ks;
    has_out = 1'b0;
    ks_out  = 8'h00;
    case (kind)
      REQ_KEY: begin
        // key byte is sign-extended before folding
        ks_hash = (ks_hash << 5) ^ ks_hash ^ {{24{val[7]}}, val};
      end
      REQ_SEED: begin
        ofs = 32'h0;
        for (int i = 0; i < N_LFSR; i++) begin
          seed = ks_hash ^ ofs;
          if (seed == 32'h0) seed = 32'h1;  // an all-zero LFSR would lock up
          ks_lfsr[i] = seed;
          ofs = ofs + STRIDE;
        end
        ks_hash = SALT;
      end
      REQ_DATA: begin
        ks = 8'h00;
        for (int rnd = 0; rnd < 8; rnd++) begin
          for (int i = 0; i < N_LFSR; i++) begin
            b[i] = ks_lfsr[i][0];
            ks_lfsr[i] = ks_lfsr[i] >> 1;
            if (b[i]) ks_lfsr[i] = ks_lfsr[i] ^ LFSR_TAPS[i];
          end
          // three Geffe selects plus two plain taps, packed MSB first
          ks = {ks[6:0], (b[0] ? b[1] : b[2]) ^ (b[3] ? b[4] : b[5]) ^
                         (b[6] ? b[7] : b[8]) ^ b[9] ^ b[10]};
        end
        ks_out  = val ^ ks;
        has_out = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Eight key bytes that take the hash from the salt to 'target'. The fold
  // is linear over GF(2), so each byte bit contributes a fixed column; solve
  // by elimination, tracking which bits make up each basis vector.
  function automatic logic [63:0] key_bytes_for_hash(input logic [31:0] target);
    logic [31:0] basis [32];
    logic [63:0] combo [32];
    logic [31:0] col, rest;
    logic [63:0] cmb, sol;
    for (int p = 0; p < 32; p++) begin
      basis[p] = 32'h0;
      combo[p] = 64'h0;
    end
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < 8; j++) begin
        col = (j == 7) ? 32'hFFFF_FF80 : (32'h1 << j);
        for (int m = 0; m < 7 - k; m++) col = col ^ (col << 5);
        cmb = 64'h1 << (8 * k + j);
        for (int p = 31; p >= 0; p--) begin
          if (col[p]) begin
            if (basis[p] != 32'h0) begin
              col = col ^ basis[p];
              cmb = cmb ^ combo[p];
            end else begin
              basis[p] = col;
              combo[p] = cmb;
              col = 32'h0;
            end
          end
        end
      end
    end
    rest = SALT;
    for (int m = 0; m < 8; m++) rest = rest ^ (rest << 5);
    rest = rest ^ target;
    sol = 64'h0;
    for (int p = 31; p >= 0; p--) begin
      if (rest[p] && basis[p] != 32'h0) begin
        rest = rest ^ basis[p];
        sol  = sol ^ combo[p];
      end
    end
    return sol;
  endfunction

  // Drive one input beat from a falling edge, hold it until accepted, then
  // record what it should produce. Returns at the next falling edge.
  task automatic send_beat(input logic [1:0] kind, input logic [7:0] val,
                           input bit has_fixed, input logic [7:0] fixed_out);
    bit has_out;
    logic [7:0] pred;
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cipher_apply(kind, val, has_out, pred);
    if (has_out) expected_bytes.push_back(has_fixed ? fixed_out : pred);
    @(negedge clk);
  endtask

  // One beat followed by a random idle gap on the input side.
  task automatic offer(input logic [1:0] kind, input logic [7:0] val);
    int n;
    send_beat(kind, val, 1'b0, 8'h00);
    n = idle_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result, plus a short tail.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // Random traffic: some key bytes, a seed, then a run of data bytes.
  // Some sessions skip the seed; dropped and stray requests are mixed in.
  task automatic run_traffic(input int n_items);
    int done_cnt, n_key, n_data;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      n_key = $urandom_range(0, 6);
      for (int i = 0; i < n_key; i++) begin
        offer(REQ_KEY, 8'($urandom));
        done_cnt++;
      end
      if ($urandom_range(0, 9) != 0) begin
        offer(REQ_SEED, 8'($urandom));
        done_cnt++;
      end
      n_data = $urandom_range(1, 16);
      for (int i = 0; i < n_data; i++) begin
        offer(REQ_DATA, 8'($urandom));
        done_cnt++;
      end
      if ($urandom_range(0, 7) == 0) offer(REQ_UNUSED, 8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        offer(2'($urandom_range(0, 2)), 8'($urandom));
        done_cnt++;
      end
    end
  endtask

  // Sink ready: random stalls, or one long hold-off when requested.
  initial begin : sink_ready
    int n;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_sink = 1'b0;
      end else begin
        n = idle_len();
        out_ready <= (n == 0);
        repeat ((n == 0) ? 1 : n) @(negedge clk);
      end
    end
  end

  // Result checker: every accepted output beat against the oldest expectation.
  initial begin : result_check
    logic [7:0] exp_byte;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output beat, expected none actual %02h",
                   $realtime, out_byte);
          mismatch_cnt++;
        end else begin
          exp_byte = expected_bytes.pop_front();
          if (out_byte !== exp_byte) begin
            $display("%0t: out_byte mismatch, expected %02h actual %02h",
                     $realtime, exp_byte, out_byte);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("geffe_lfsr_stream_cipher test failed");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] zero_key;
    for (int i = 0; i < N_LFSR; i++) ks_lfsr[i] = 32'h0;
    ks_hash = SALT;

    // Directed table. Before any seed the LFSRs are zero, so data passes
    // through untouched and the expected byte is the input byte.
    directed_rows.push_back('{REQ_DATA,   8'h00, 1'b1, 8'h00});
    directed_rows.push_back('{REQ_DATA,   8'hFF, 1'b1, 8'hFF});
    directed_rows.push_back('{REQ_UNUSED, 8'h3C, 1'b0, 8'h00});
    // seed straight from the salt, value is ignored
    directed_rows.push_back('{REQ_SEED,   8'hA5, 1'b0, 8'h00});
    directed_rows.push_back('{REQ_DATA,   8'h00, 1'b0, 8'h00});
    // zero key byte, and both sides of the sign extension
    directed_rows.push_back('{REQ_KEY,    8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{REQ_KEY,    8'h80, 1'b0, 8'h00});
    directed_rows.push_back('{REQ_KEY,    8'hFF, 1'b0, 8'h00});
    directed_rows.push_back('{REQ_KEY,    8'h7F, 1'b0, 8'h00});
    directed_rows.push_back('{REQ_SEED,   8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{REQ_DATA,   8'hFF, 1'b0, 8'h00});
    // back-to-back reseed: hash is the salt again
    directed_rows.push_back('{REQ_SEED,   8'hFF, 1'b0, 8'h00});
    directed_rows.push_back('{REQ_DATA,   8'h5A, 1'b0, 8'h00});
    // key bytes that drive the hash to zero, so register 0 seeds as zero
    // and must be forced to one
    zero_key = key_bytes_for_hash(32'h0);
    for (int k = 0; k < 8; k++)
      directed_rows.push_back('{REQ_KEY, zero_key[8*k +: 8], 1'b0, 8'h00});
    directed_rows.push_back('{REQ_SEED,   8'h00, 1'b0, 8'h00});
    directed_rows.push_back('{REQ_DATA,   8'hC3, 1'b0, 8'h00});

    // reset held from time zero, released on a falling edge
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].req, directed_rows[i].value,
                directed_rows[i].has_fixed, directed_rows[i].fixed_out);
      if (idle_len() > 2) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
    drain();

    run_traffic(350);
    drain();

    // Long sink hold-off while the source keeps pushing data beats: the
    // output stage fills and in_ready must drop until the sink resumes.
    hold_sink = 1'b1;
    steady    = 1'b1;
    for (int i = 0; i < 40; i++) offer(REQ_DATA, 8'($urandom));
    steady = 1'b0;
    drain();

    // full-rate stretch, no idling on either side
    steady = 1'b1;
    run_traffic(200);
    steady = 1'b0;
    drain();

    run_traffic(460);
    drain();

    if (mismatch_cnt == 0) begin
      $display("geffe_lfsr_stream_cipher test passed");
    end else begin
      $display("geffe_lfsr_stream_cipher test failed");
    end
    $finish;
  end

endmodule
